>>> rtl/core/cm2d_pkg.sv
// Shared types, constants and helpers of the 2-D contact manifold pipeline.
`default_nettype none

package cm2d_pkg;

    localparam int unsigned SQ_STG = 16;
    localparam int unsigned DV_BITS = 15;
    localparam int unsigned DV_PER = 3;
    localparam int unsigned DV_STG = DV_BITS / DV_PER;

    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
    localparam logic signed [15:0] NEG_Q14 = -16'sd16384;
    localparam logic [DV_BITS-1:0] Q_CAP = DV_BITS'(16384);

    typedef enum logic [1:0] {
        CS_BB = 2'd0,
        CS_BC = 2'd1,
        CS_CC = 2'd2
    } t_case;

    // per-request side data carried down the pipe
    typedef struct packed {
        logic               swp;
        logic               hit;
        logic               sq;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [31:0] pen;
        logic               sx;
        logic               sy;
        logic [31:0]        mx;
        logic [31:0]        my;
        logic [31:0]        rad;
    } t_meta;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] res;
        if (v > 34'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/contact_manifold_2d.sv
// Top level of the 2-D narrow-phase contact manifold pipeline.
//
// Usage: drive one body pair on the i_* payload ports and raise i_start.
// The request is taken at every rising edge with i_start high and o_busy
// low; o_busy stays low, so a new pair can enter every cycle.
// Each request produces exactly one result: o_valid is high for one cycle
// with o_hit, o_swapped, o_normal_x/y (Q2.14) and o_penetration (Q16.16).
// Pipeline: the request passes 3 geometry stages, 2 square/compare stages,
// 17 square-root stages, 6 divider stages and 1 output register.
// Throughput is one pair per cycle; the square-root and divider pipelines
// set the depth.
// Results come out in request order. The receiver cannot stall; results
// are presented once and never held.
// Reset (synchronous, active low) clears all stage valid bits; requests in
// flight are dropped and no result is shown until new requests arrive.
`default_nettype none

module contact_manifold_2d (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic               i_kind_a,
    input  wire logic               i_kind_b,
    input  wire logic signed [31:0] i_pos_a_x,
    input  wire logic signed [31:0] i_pos_a_y,
    input  wire logic [30:0]        i_size_a_x,
    input  wire logic [30:0]        i_size_a_y,
    input  wire logic signed [31:0] i_pos_b_x,
    input  wire logic signed [31:0] i_pos_b_y,
    input  wire logic [30:0]        i_size_b_x,
    input  wire logic [30:0]        i_size_b_y,
    output logic                    o_valid,
    output logic                    o_hit,
    output logic                    o_swapped,
    output logic signed [15:0]      o_normal_x,
    output logic signed [15:0]      o_normal_y,
    output logic signed [31:0]      o_penetration
);
    import cm2d_pkg::*;

    logic        g_vld, s_vld, q_vld, d_vld;
    t_meta       g_meta, s_meta, q_meta, d_meta;
    logic [63:0] s_sum;
    logic [32:0] q_len, d_len;
    logic [DV_BITS-1:0] d_qx, d_qy;

    assign o_busy = 1'b0;

    cm2d_geom u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (i_start),
        .i_kind_a   (i_kind_a),
        .i_kind_b   (i_kind_b),
        .i_pos_a_x  (i_pos_a_x),
        .i_pos_a_y  (i_pos_a_y),
        .i_size_a_x (i_size_a_x),
        .i_size_a_y (i_size_a_y),
        .i_pos_b_x  (i_pos_b_x),
        .i_pos_b_y  (i_pos_b_y),
        .i_size_b_x (i_size_b_x),
        .i_size_b_y (i_size_b_y),
        .o_vld      (g_vld),
        .o_meta     (g_meta)
    );

    cm2d_sqr u_sqr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (g_vld),
        .i_meta  (g_meta),
        .o_vld   (s_vld),
        .o_meta  (s_meta),
        .o_sum   (s_sum)
    );

    cm2d_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_vld),
        .i_meta  (s_meta),
        .i_val   (s_sum),
        .o_vld   (q_vld),
        .o_meta  (q_meta),
        .o_len   (q_len)
    );

    cm2d_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (q_vld),
        .i_meta  (q_meta),
        .i_len   (q_len),
        .o_vld   (d_vld),
        .o_meta  (d_meta),
        .o_len   (d_len),
        .o_qx    (d_qx),
        .o_qy    (d_qy)
    );

    // output stage
    logic [DV_BITS-1:0] w_qx, w_qy;
    logic signed [15:0] n_nx, n_ny, r_nx, r_ny;
    logic signed [31:0] n_pen, r_pen;
    logic               r_vld, r_hit, r_swp;

    always_comb begin
        w_qx  = (d_qx > Q_CAP) ? Q_CAP : d_qx;
        w_qy  = (d_qy > Q_CAP) ? Q_CAP : d_qy;
        n_nx  = d_meta.nx;
        n_ny  = d_meta.ny;
        n_pen = d_meta.pen;
        if (d_meta.sq) begin
            n_nx  = d_meta.sx ? (16'sd0 - $signed({1'b0, w_qx})) : $signed({1'b0, w_qx});
            n_ny  = d_meta.sy ? (16'sd0 - $signed({1'b0, w_qy})) : $signed({1'b0, w_qy});
            n_pen = sat32($signed({2'b00, d_meta.rad}) - $signed({1'b0, d_len}));
        end
        if (!d_meta.hit) begin
            n_nx  = '0;
            n_ny  = '0;
            n_pen = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= d_meta.hit;
        r_swp <= d_meta.swp;
        r_nx  <= n_nx;
        r_ny  <= n_ny;
        r_pen <= n_pen;
    end

    assign o_valid       = r_vld;
    assign o_hit         = r_hit;
    assign o_swapped     = r_swp;
    assign o_normal_x    = r_nx;
    assign o_normal_y    = r_ny;
    assign o_penetration = r_pen;

endmodule

`default_nettype wire

>>> rtl/core/cm2d_geom.sv
// Geometry front end: offsets, overlaps, clamping and direct contact cases.
`default_nettype none

module cm2d_geom (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_vld,
    input  wire logic               i_kind_a,
    input  wire logic               i_kind_b,
    input  wire logic signed [31:0] i_pos_a_x,
    input  wire logic signed [31:0] i_pos_a_y,
    input  wire logic [30:0]        i_size_a_x,
    input  wire logic [30:0]        i_size_a_y,
    input  wire logic signed [31:0] i_pos_b_x,
    input  wire logic signed [31:0] i_pos_b_y,
    input  wire logic [30:0]        i_size_b_x,
    input  wire logic [30:0]        i_size_b_y,
    output logic                    o_vld,
    output cm2d_pkg::t_meta         o_meta
);
    import cm2d_pkg::*;

    // stage 1
    t_case       n1_cs, r1_cs;
    logic        n1_swp, r1_swp;
    logic [32:0] n1_dx, n1_dy, r1_dx, r1_dy;
    logic [30:0] n1_ex, n1_ey, n1_rad;
    logic [30:0] r1_ex, r1_ey, r1_hx, r1_hy, r1_rad;
    logic        r1_vld;

    always_comb begin
        n1_swp = i_kind_a & ~i_kind_b;
        case ({i_kind_a, i_kind_b})
            2'b00:   n1_cs = CS_BB;
            2'b11:   n1_cs = CS_CC;
            default: n1_cs = CS_BC;
        endcase
        n1_dx = {i_pos_b_x[31], i_pos_b_x} - {i_pos_a_x[31], i_pos_a_x};
        n1_dy = {i_pos_b_y[31], i_pos_b_y} - {i_pos_a_y[31], i_pos_a_y};
        if (n1_swp) begin
            n1_dx = 33'd0 - n1_dx;
            n1_dy = 33'd0 - n1_dy;
        end
        n1_ex  = n1_swp ? i_size_b_x : i_size_a_x;
        n1_ey  = n1_swp ? i_size_b_y : i_size_a_y;
        n1_rad = (n1_swp || n1_cs == CS_CC) ? i_size_a_x : i_size_b_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_cs  <= n1_cs;
        r1_swp <= n1_swp;
        r1_dx  <= n1_dx;
        r1_dy  <= n1_dy;
        r1_ex  <= n1_ex;
        r1_ey  <= n1_ey;
        r1_hx  <= i_size_b_x;
        r1_hy  <= i_size_b_y;
        r1_rad <= n1_rad;
    end

    // stage 2
    logic [32:0]        n2_adf, n2_ayf;
    logic [31:0]        n2_adx, n2_ady;
    logic               n2_inx, n2_iny, n2_xax;
    logic signed [33:0] n2_ox, n2_oy, r2_ox, r2_oy;
    logic [31:0]        n2_mx, n2_my, n2_r, r2_mx, r2_my, r2_r;
    logic [30:0]        n2_len, r2_len;
    logic               n2_pos, r2_pos;
    t_case              r2_cs;
    logic               r2_swp, r2_in, r2_xax, r2_sx, r2_sy, r2_zero, r2_vld;
    logic [30:0]        r2_rad;

    always_comb begin
        n2_adf = r1_dx[32] ? (33'd0 - r1_dx) : r1_dx;
        n2_ayf = r1_dy[32] ? (33'd0 - r1_dy) : r1_dy;
        n2_adx = n2_adf[31:0];
        n2_ady = n2_ayf[31:0];
        n2_ox  = $signed({3'b000, r1_ex}) + $signed({3'b000, r1_hx})
               - $signed({2'b00, n2_adx});
        n2_oy  = $signed({3'b000, r1_ey}) + $signed({3'b000, r1_hy})
               - $signed({2'b00, n2_ady});
        n2_inx = n2_adx <= {1'b0, r1_ex};
        n2_iny = n2_ady <= {1'b0, r1_ey};
        n2_xax = n2_adx > n2_ady;
        if (r1_cs == CS_CC) begin
            n2_mx = n2_adx;
            n2_my = n2_ady;
            n2_r  = {1'b0, r1_rad} + {1'b0, r1_hx};
        end else begin
            n2_mx = n2_inx ? 32'd0 : n2_adx - {1'b0, r1_ex};
            n2_my = n2_iny ? 32'd0 : n2_ady - {1'b0, r1_ey};
            n2_r  = {1'b0, r1_rad};
        end
        n2_len = n2_xax ? (r1_ex - n2_adx[30:0]) : (r1_ey - n2_ady[30:0]);
        n2_pos = n2_xax ? (!r1_dx[32] && r1_dx != 33'd0)
                        : (!r1_dy[32] && r1_dy != 33'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_cs   <= r1_cs;
        r2_swp  <= r1_swp;
        r2_ox   <= n2_ox;
        r2_oy   <= n2_oy;
        r2_in   <= n2_inx & n2_iny;
        r2_len  <= n2_len;
        r2_xax  <= n2_xax;
        r2_pos  <= n2_pos;
        r2_sx   <= r1_dx[32];
        r2_sy   <= r1_dy[32];
        r2_mx   <= n2_mx;
        r2_my   <= n2_my;
        r2_r    <= n2_r;
        r2_rad  <= r1_rad;
        r2_zero <= (n2_adx == 32'd0) && (n2_ady == 32'd0);
    end

    // stage 3
    t_meta n3_meta, r3_meta;
    logic  r3_vld;

    always_comb begin
        n3_meta     = '0;
        n3_meta.swp = r2_swp;
        n3_meta.sx  = r2_sx;
        n3_meta.sy  = r2_sy;
        n3_meta.mx  = r2_mx;
        n3_meta.my  = r2_my;
        n3_meta.rad = r2_r;
        case (r2_cs)
            CS_BB: begin
                n3_meta.hit = (r2_ox > 34'sd0) && (r2_oy > 34'sd0);
                if (r2_ox < r2_oy) begin
                    n3_meta.nx  = r2_sx ? NEG_Q14 : ONE_Q14;
                    n3_meta.pen = sat32(r2_ox);
                end else begin
                    n3_meta.ny  = r2_sy ? NEG_Q14 : ONE_Q14;
                    n3_meta.pen = sat32(r2_oy);
                end
            end
            CS_BC: begin
                if (r2_in) begin
                    n3_meta.hit = 1'b1;
                    if (r2_len == 31'd0) begin
                        n3_meta.nx  = ONE_Q14;
                        n3_meta.pen = $signed({1'b0, r2_rad});
                    end else begin
                        if (r2_xax) begin
                            n3_meta.nx = r2_pos ? ONE_Q14 : NEG_Q14;
                        end else begin
                            n3_meta.ny = r2_pos ? ONE_Q14 : NEG_Q14;
                        end
                        n3_meta.pen = $signed({1'b0, r2_rad}) - $signed({1'b0, r2_len});
                    end
                end else begin
                    n3_meta.sq  = 1'b1;
                    n3_meta.hit = (r2_mx <= r2_r) && (r2_my <= r2_r);
                end
            end
            CS_CC: begin
                if (r2_zero) begin
                    n3_meta.hit = 1'b1;
                    n3_meta.nx  = ONE_Q14;
                    n3_meta.pen = $signed({1'b0, r2_rad});
                end else begin
                    n3_meta.sq  = 1'b1;
                    n3_meta.hit = (r2_mx <= r2_r) && (r2_my <= r2_r);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_meta <= n3_meta;
    end

    assign o_vld  = r3_vld;
    assign o_meta = r3_meta;

endmodule

`default_nettype wire

>>> rtl/core/cm2d_sqr.sv
// Squared lengths and the reach test against the squared radius or radius sum.
`default_nettype none

module cm2d_sqr (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_vld,
    input  cm2d_pkg::t_meta      i_meta,
    output logic                 o_vld,
    output cm2d_pkg::t_meta      o_meta,
    output logic [63:0]          o_sum
);
    import cm2d_pkg::*;

    logic [63:0] r4_px, r4_py, r4_rr;
    t_meta       r4_meta, n5_meta, r5_meta;
    logic        r4_vld, r5_vld;
    logic [64:0] n5_sum;
    logic [63:0] r5_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            r4_vld <= i_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_px   <= i_meta.mx * i_meta.mx;
        r4_py   <= i_meta.my * i_meta.my;
        r4_rr   <= i_meta.rad * i_meta.rad;
        r4_meta <= i_meta;
    end

    always_comb begin
        n5_sum  = {1'b0, r4_px} + {1'b0, r4_py};
        n5_meta = r4_meta;
        if (r4_meta.sq && n5_sum > {1'b0, r4_rr}) begin
            n5_meta.hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_meta <= n5_meta;
        r5_sum  <= n5_sum[63:0];
    end

    assign o_vld  = r5_vld;
    assign o_meta = r5_meta;
    assign o_sum  = r5_sum;

endmodule

`default_nettype wire

>>> rtl/core/cm2d_sqrt.sv
// Pipelined integer square root, two root bits per stage, rounded to nearest.
`default_nettype none

module cm2d_sqrt (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_vld,
    input  cm2d_pkg::t_meta      i_meta,
    input  wire logic [63:0]     i_val,
    output logic                 o_vld,
    output cm2d_pkg::t_meta      o_meta,
    output logic [32:0]          o_len
);
    import cm2d_pkg::*;

    typedef struct packed {
        logic [63:0] rem;
        logic [64:0] root;
    } t_sqs;

    function automatic t_sqs sq_step(input logic [63:0] rem, input logic [64:0] root,
                                     input logic [64:0] bv);
        t_sqs        res;
        logic [64:0] trial;
        trial = root + bv;
        if ({1'b0, rem} >= trial) begin
            res.rem  = rem - trial[63:0];
            res.root = (root >> 1) + bv;
        end else begin
            res.rem  = rem;
            res.root = root >> 1;
        end
        return res;
    endfunction

    logic [SQ_STG-1:0] r_vld;
    t_meta             r_meta [SQ_STG];
    logic [63:0]       r_rem  [SQ_STG];
    logic [64:0]       r_root [SQ_STG];

    for (genvar k = 0; k < SQ_STG; k++) begin : g_stg
        logic [63:0] w_rem;
        logic [64:0] w_root;
        t_meta       w_meta;
        logic        w_vld;
        t_sqs        s0, s1;

        if (k == 0) begin : g_first
            assign w_rem  = i_val;
            assign w_root = '0;
            assign w_meta = i_meta;
            assign w_vld  = i_vld;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_meta = r_meta[k-1];
            assign w_vld  = r_vld[k-1];
        end

        assign s0 = sq_step(w_rem, w_root, 65'd1 << (62 - 4 * k));
        assign s1 = sq_step(s0.rem, s0.root, 65'd1 << (60 - 4 * k));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= s1.rem;
            r_root[k] <= s1.root;
            r_meta[k] <= w_meta;
        end
    end

    // round to nearest: bump when the remainder exceeds the root
    logic [31:0] w_root_f;
    logic        w_up;
    logic [32:0] r_len;
    t_meta       r_ometa;
    logic        r_ovld;

    assign w_root_f = r_root[SQ_STG-1][31:0];
    assign w_up     = {1'b0, r_rem[SQ_STG-1]} > r_root[SQ_STG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_vld[SQ_STG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= {1'b0, w_root_f} + {32'd0, w_up};
        r_ometa <= r_meta[SQ_STG-1];
    end

    assign o_vld  = r_ovld;
    assign o_meta = r_ometa;
    assign o_len  = r_len;

endmodule

`default_nettype wire

>>> rtl/core/cm2d_div.sv
// Pipelined restoring divider for both normal components, rounded to nearest.
`default_nettype none

module cm2d_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    input  cm2d_pkg::t_meta                    i_meta,
    input  wire logic [32:0]                   i_len,
    output logic                               o_vld,
    output cm2d_pkg::t_meta                    o_meta,
    output logic [32:0]                        o_len,
    output logic [cm2d_pkg::DV_BITS-1:0]       o_qx,
    output logic [cm2d_pkg::DV_BITS-1:0]       o_qy
);
    import cm2d_pkg::*;

    logic [DV_STG:0] r_vld;
    t_meta           r_meta [DV_STG+1];
    logic [32:0]     r_len  [DV_STG+1];
    logic [47:0]     r_rx   [DV_STG+1];
    logic [47:0]     r_ry   [DV_STG+1];
    logic [DV_BITS-1:0] r_qx [DV_STG+1];
    logic [DV_BITS-1:0] r_qy [DV_STG+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    // numerator: |c| * 2^14 + len / 2
    always_ff @(posedge i_clk) begin
        r_meta[0] <= i_meta;
        r_len[0]  <= i_len;
        r_rx[0]   <= {2'b00, i_meta.mx, 14'd0} + {16'd0, i_len[32:1]};
        r_ry[0]   <= {2'b00, i_meta.my, 14'd0} + {16'd0, i_len[32:1]};
        r_qx[0]   <= '0;
        r_qy[0]   <= '0;
    end

    for (genvar k = 0; k < DV_STG; k++) begin : g_stg
        logic [47:0]        w_rx, w_ry, dsh;
        logic [DV_BITS-1:0] w_qx, w_qy;

        always_comb begin
            w_rx = r_rx[k];
            w_ry = r_ry[k];
            w_qx = r_qx[k];
            w_qy = r_qy[k];
            dsh  = '0;
            for (int j = 0; j < DV_PER; j++) begin
                dsh = {15'd0, r_len[k]} << (DV_BITS - 1 - DV_PER * k - j);
                if (w_rx >= dsh) begin
                    w_rx = w_rx - dsh;
                    w_qx[DV_BITS-1-DV_PER*k-j] = 1'b1;
                end
                if (w_ry >= dsh) begin
                    w_ry = w_ry - dsh;
                    w_qy[DV_BITS-1-DV_PER*k-j] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_meta[k+1] <= r_meta[k];
            r_len[k+1]  <= r_len[k];
            r_rx[k+1]   <= w_rx;
            r_ry[k+1]   <= w_ry;
            r_qx[k+1]   <= w_qx;
            r_qy[k+1]   <= w_qy;
        end
    end

    assign o_vld  = r_vld[DV_STG];
    assign o_meta = r_meta[DV_STG];
    assign o_len  = r_len[DV_STG];
    assign o_qx   = r_qx[DV_STG];
    assign o_qy   = r_qy[DV_STG];

endmodule

`default_nettype wire

>>> rtl/core/cm2d_checker.sv
// Port-level checks for the contact manifold top level, bound to it.
`default_nettype none

module cm2d_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_start,
    input wire logic               o_busy,
    input wire logic               i_kind_a,
    input wire logic               i_kind_b,
    input wire logic signed [31:0] i_pos_a_x,
    input wire logic signed [31:0] i_pos_a_y,
    input wire logic [30:0]        i_size_a_x,
    input wire logic [30:0]        i_size_a_y,
    input wire logic signed [31:0] i_pos_b_x,
    input wire logic signed [31:0] i_pos_b_y,
    input wire logic [30:0]        i_size_b_x,
    input wire logic [30:0]        i_size_b_y,
    input wire logic               o_valid,
    input wire logic               o_hit,
    input wire logic               o_swapped,
    input wire logic signed [15:0] o_normal_x,
    input wire logic signed [15:0] o_normal_y,
    input wire logic signed [31:0] o_penetration
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_normal_x == 16'sd0 && o_normal_y == 16'sd0
                              && o_penetration == 32'sd0)
        else $error("miss with nonzero contact data");

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_normal_x <= 16'sd16384 && o_normal_x >= -16'sd16384
                    && o_normal_y <= 16'sd16384 && o_normal_y >= -16'sd16384)
        else $error("normal out of unit range");

    a_hit_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_normal_x != 16'sd0 || o_normal_y != 16'sd0)
        else $error("hit with zero normal");

endmodule

bind contact_manifold_2d cm2d_checker u_cm2d_checker (.*);

`default_nettype wire
